>>> hw/rtl/czp_pkg.sv
// ============================================================================
// czp_pkg
// Shared types, constants and helpers for the zero-padded 2D convolution.
// ============================================================================
`default_nettype none

package czp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_KERNEL = 5;
    localparam int NCOEF      = MAX_KERNEL * MAX_KERNEL;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int LANES      = MAX_KERNEL - 1;
    localparam int LB_W       = 16 * LANES;
    localparam int PROD_W     = 32;
    localparam int ROW_W      = 35;
    localparam int SUM_W      = 36;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KSIZE  = 2'd2;

    typedef logic [PROD_W-1:0] t_prod;

    // effective (saturated) configuration
    typedef struct packed {
        logic [10:0] w;
        logic [10:0] h;
        logic [2:0]  s;
        logic [1:0]  f;     // forward reach of the window
        logic [11:0] lag;   // f*w + f
    } t_cfg;

    // one item entering the window stage
    typedef struct packed {
        logic        is_load;
        logic        is_shift;
        logic        emit;
        logic        fin;
        logic [4:0]  cidx;
        logic [15:0] cval;
        logic [15:0] sample;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [ADDR_W-1:0] addr;
    } t_item;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_meta;

    function automatic logic [1:0] kernel_fwd(input logic [2:0] s);
        logic [2:0] t;
        t = s - 3'd1 - (s >> 1);
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/czp_linebuf.sv
// ============================================================================
// czp_linebuf
// Line buffer memory: one word per column, one 16-bit lane per buffered row.
// ============================================================================
`default_nettype none

module czp_linebuf (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_re,
    input  wire logic [czp_pkg::ADDR_W-1:0] i_raddr,
    input  wire logic                       i_we,
    input  wire logic [czp_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [czp_pkg::LB_W-1:0]   i_wdata,
    output logic      [czp_pkg::LB_W-1:0]   o_rdata
);
    import czp_pkg::*;

    logic [LB_W-1:0] mem [MAX_WIDTH];
    logic [LB_W-1:0] r_rd;
    logic [LB_W-1:0] r_wsave;
    logic            r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd    <= mem[i_raddr];
            r_wsave <= i_wdata;
        end
    end

    // read colliding with a write of the same column returns the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_re) begin
            r_byp <= i_we && (i_raddr == i_waddr);
        end
    end

    assign o_rdata = r_byp ? r_wsave : r_rd;

endmodule

`default_nettype wire

>>> hw/rtl/czp_ctrl.sv
// ============================================================================
// czp_ctrl
// Input sequencing: frame counters, emit positions and end-of-frame padding.
// ============================================================================
`default_nettype none

module czp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire czp_pkg::t_cfg i_cfg,
    input  wire logic          i_restart,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_op,
    input  wire logic [4:0]    i_cidx,
    input  wire logic [15:0]   i_cval,
    input  wire logic [15:0]   i_sample,
    input  wire logic          i_free,
    output logic               o_ready,
    output logic               o_push,
    output czp_pkg::t_item     o_item
);
    import czp_pkg::*;

    logic [10:0]       r_in_row, n_in_row;
    logic [9:0]        r_in_col, n_in_col;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [11:0]       r_cnt,    n_cnt;
    logic [9:0]        r_er,     n_er;
    logic [9:0]        r_ec,     n_ec;

    logic frame_done, pad, sample_ok, drain_ok, load_ok, accept, shift, emit, fin;

    always_comb begin
        frame_done = r_in_row >= i_cfg.h;
        // frames shorter than the lag: shift dummy beats until the window lines up
        pad        = frame_done && (r_cnt < i_cfg.lag);
        sample_ok  = (i_op == OP_PIXEL) && !frame_done;
        drain_ok   = (i_op == OP_DRAIN) && frame_done;
        load_ok    = (i_op == OP_LOAD) && (i_cidx < 5'(NCOEF));
        o_ready    = i_free && !pad;
        accept     = i_valid && o_ready;
        shift      = pad || sample_ok || drain_ok;
        emit       = !pad && (drain_ok || (sample_ok && (r_cnt >= i_cfg.lag)));
        fin        = emit && (11'(r_er) == i_cfg.h - 11'd1) && (11'(r_ec) == i_cfg.w - 11'd1);
        o_push     = pad ? i_free : (accept && (load_ok || sample_ok || drain_ok));

        o_item.is_load  = !pad && load_ok;
        o_item.is_shift = shift;
        o_item.emit     = emit;
        o_item.fin      = fin;
        o_item.cidx     = i_cidx;
        o_item.cval     = i_cval;
        o_item.sample   = i_sample;
        o_item.row      = r_er;
        o_item.col      = r_ec;
        o_item.addr     = r_addr;
    end

    always_comb begin
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_er     = r_er;
        n_ec     = r_ec;
        if (i_restart) begin
            n_in_row = '0;
            n_in_col = '0;
            n_addr   = '0;
            n_cnt    = '0;
            n_er     = '0;
            n_ec     = '0;
        end else if (o_push && shift) begin
            if (11'(r_addr) + 11'd1 == i_cfg.w) begin
                n_addr = '0;
            end else begin
                n_addr = r_addr + ADDR_W'(1);
            end
            if (r_cnt != 12'hFFF) begin
                n_cnt = r_cnt + 12'd1;
            end
            if (!pad && sample_ok) begin
                if (11'(r_in_col) + 11'd1 == i_cfg.w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 11'd1;
                end else begin
                    n_in_col = r_in_col + 10'd1;
                end
            end
            if (fin) begin
                n_in_row = '0;
                n_in_col = '0;
                n_addr   = '0;
                n_cnt    = '0;
                n_er     = '0;
                n_ec     = '0;
            end else if (emit) begin
                if (11'(r_ec) + 11'd1 == i_cfg.w) begin
                    n_ec = '0;
                    n_er = r_er + 10'd1;
                end else begin
                    n_ec = r_ec + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_er     <= '0;
            r_ec     <= '0;
        end else begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_er     <= n_er;
            r_ec     <= n_ec;
        end
    end

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (11'(r_ec) < i_cfg.w) && (11'(r_er) < i_cfg.h))
        else $error("emit position outside frame");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (11'(r_addr) < i_cfg.w) && (11'(r_in_col) < i_cfg.w))
        else $error("column counter outside row");

    a_fin_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.fin && !i_restart) |=> (r_in_row == '0) && (r_cnt == '0))
        else $error("frame did not restart after last output");

endmodule

`default_nettype wire

>>> hw/rtl/czp_window.sv
// ============================================================================
// czp_window
// Window shift register, coefficient store, masking and product stage.
// ============================================================================
`default_nettype none

module czp_window (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire czp_pkg::t_cfg                i_cfg,
    input  wire logic                         i_push,
    input  wire czp_pkg::t_item               i_item,
    output logic                              o_free,
    input  wire logic [czp_pkg::LB_W-1:0]     i_lanes,
    output logic                              o_we,
    output logic [czp_pkg::ADDR_W-1:0]        o_waddr,
    output logic [czp_pkg::LB_W-1:0]          o_wdata,
    output logic                              o_v1,
    output czp_pkg::t_prod [czp_pkg::NCOEF-1:0] o_prod,
    output czp_pkg::t_meta                    o_meta,
    input  wire logic                         i_take
);
    import czp_pkg::*;

    logic        r_v0;
    t_item       r_s0;
    logic        r_v1;
    t_meta       r_meta;
    t_prod [NCOEF-1:0] r_prod, n_prod;
    logic [15:0] r_win  [MAX_KERNEL][MAX_KERNEL];
    logic [15:0] n_win  [MAX_KERNEL][MAX_KERNEL];
    logic [15:0] kc     [MAX_KERNEL][MAX_KERNEL];
    logic [15:0] r_coef [NCOEF];
    logic [15:0] col    [MAX_KERNEL];
    logic        rmask  [MAX_KERNEL];
    logic        cmask  [MAX_KERNEL];
    logic        adv0, adv1;

    assign adv1   = r_v1 && i_take;
    assign adv0   = r_v0 && (!r_s0.emit || !r_v1 || i_take);
    assign o_free = !r_v0 || adv0;

    // new column: sample on top, then each buffered row one line older
    always_comb begin
        col[0] = r_s0.sample;
        for (int k = 1; k < MAX_KERNEL; k++) begin
            col[k] = i_lanes[16*(k-1) +: 16];
        end
        for (int k = 0; k < MAX_KERNEL; k++) begin
            n_win[k][0] = col[k];
            for (int j = 1; j < MAX_KERNEL; j++) begin
                n_win[k][j] = r_win[k][j-1];
            end
        end
    end

    assign o_we    = adv0 && r_s0.is_shift;
    assign o_waddr = r_s0.addr;
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_wdata[16*k +: 16] = col[k];
        end
    end

    // window (k,j) holds raster index t - k*W - j; negative offsets wrap huge
    always_comb begin
        logic [12:0] rr;
        logic [12:0] cc;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            rr       = 13'(r_s0.row) + 13'(i_cfg.f) - 13'(k);
            cc       = 13'(r_s0.col) + 13'(i_cfg.f) - 13'(k);
            rmask[k] = (k < int'(i_cfg.s)) && (rr < 13'(i_cfg.h));
            cmask[k] = (k < int'(i_cfg.s)) && (cc < 13'(i_cfg.w));
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_KERNEL; k++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                kc[k][j] = '0;
                for (int z = 1; z <= MAX_KERNEL; z++) begin
                    if ((int'(i_cfg.s) == z) && (k < z) && (j < z)) begin
                        kc[k][j] = r_coef[k*z+j];
                    end
                end
            end
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] p;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                p = $signed(n_win[k][j]) * $signed(kc[k][j]);
                n_prod[k*MAX_KERNEL+j] = (rmask[k] && cmask[j]) ? t_prod'(p) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_push) begin
                r_v0 <= 1'b1;
            end else if (adv0) begin
                r_v0 <= 1'b0;
            end
            if (adv0 && r_s0.emit) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv0 && r_s0.is_load) begin
                r_coef[r_s0.cidx] <= r_s0.cval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s0 <= i_item;
        end
        if (adv0 && r_s0.is_shift) begin
            r_win <= n_win;
        end
        if (adv0 && r_s0.emit) begin
            r_prod      <= n_prod;
            r_meta.row  <= r_s0.row;
            r_meta.col  <= r_s0.col;
            r_meta.last <= r_s0.fin;
        end
    end

    assign o_v1   = r_v1;
    assign o_prod = r_prod;
    assign o_meta = r_meta;

endmodule

`default_nettype wire

>>> hw/rtl/czp_sum.sv
// ============================================================================
// czp_sum
// Two-level registered adder tree and output register.
// ============================================================================
`default_nettype none

module czp_sum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_v,
    input  wire czp_pkg::t_prod [czp_pkg::NCOEF-1:0] i_prod,
    input  wire czp_pkg::t_meta                 i_meta,
    output logic                                o_take,
    output logic                                o_valid,
    output logic [czp_pkg::SUM_W-1:0]           o_value,
    output czp_pkg::t_meta                      o_meta,
    input  wire logic                           i_ready
);
    import czp_pkg::*;

    logic             r_v2;
    logic [ROW_W-1:0] r_rows [MAX_KERNEL];
    logic [ROW_W-1:0] n_rows [MAX_KERNEL];
    t_meta            r_m2;
    logic             r_ov;
    logic [SUM_W-1:0] r_sum, n_sum;
    t_meta            r_mo;
    logic             free_out, adv2;

    assign free_out = !r_ov || i_ready;
    assign adv2     = r_v2 && free_out;
    assign o_take   = !r_v2 || adv2;

    always_comb begin
        for (int k = 0; k < MAX_KERNEL; k++) begin
            n_rows[k] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                n_rows[k] = n_rows[k] + ROW_W'($signed(i_prod[k*MAX_KERNEL+j]));
            end
        end
        n_sum = '0;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            n_sum = n_sum + SUM_W'($signed(r_rows[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_v && o_take) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_v && o_take) begin
            r_rows <= n_rows;
            r_m2   <= i_meta;
        end
        if (adv2) begin
            r_sum <= n_sum;
            r_mo  <= r_m2;
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_sum;
    assign o_meta  = r_mo;

endmodule

`default_nettype wire

>>> hw/rtl/zero_padded_2d_convolution.sv
// ============================================================================
// zero_padded_2d_convolution
// 2D convolution of a raster stream with a flipped square kernel, zero padded.
// ============================================================================
// Stages: item, window/product, row sums, then total (the output register).
// Throughput: one beat per cycle unless stalled by the output or padding;
// line buffer and window take a column a cycle while the pipe advances.
// Frames shorter than the window lag insert lag - W*H dummy shifts at frame end.
// Reset: synchronous; control, counters and coefficients clear, line buffer
// and window data are not cleared (stale entries are masked by position).
`default_nettype none

module zero_padded_2d_convolution (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] coeff_index, [20:5] coeff_value, [36:21] sample, [39:37] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [35:0] filtered_value, [45:36] out_row, [55:46] out_col
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import czp_pkg::*;

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [2:0]  r_ksize;
    logic        wr, restart;
    t_cfg        cfg;

    logic              push, free0, take, v1, we, sum_valid;
    t_item             item;
    logic [LB_W-1:0]   lanes, wdata;
    logic [ADDR_W-1:0] waddr;
    t_prod [NCOEF-1:0] prod;
    t_meta             meta1, meta_o;
    logic [SUM_W-1:0]  value;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign restart = wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT) ||
                            (paddr[3:2] == REG_KSIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd32;
            r_height <= 11'd32;
            r_ksize  <= 3'd5;
        end else if (wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[10:0];
                REG_HEIGHT: r_height <= pwdata[10:0];
                REG_KSIZE:  r_ksize  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {21'd0, r_height};
            REG_KSIZE:  prdata = {29'd0, r_ksize};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            cfg.w = 11'd1;
        end else if (r_width > 11'(MAX_WIDTH)) begin
            cfg.w = 11'(MAX_WIDTH);
        end else begin
            cfg.w = r_width;
        end
        if (r_height == '0) begin
            cfg.h = 11'd1;
        end else if (r_height > 11'(MAX_HEIGHT)) begin
            cfg.h = 11'(MAX_HEIGHT);
        end else begin
            cfg.h = r_height;
        end
        if (r_ksize == '0) begin
            cfg.s = 3'd1;
        end else if (r_ksize > 3'(MAX_KERNEL)) begin
            cfg.s = 3'(MAX_KERNEL);
        end else begin
            cfg.s = r_ksize;
        end
        cfg.f = kernel_fwd(cfg.s);
        case (cfg.f)
            2'd1:    cfg.lag = 12'(cfg.w) + 12'd1;
            2'd2:    cfg.lag = {cfg.w, 1'b0} + 12'd2;
            default: cfg.lag = '0;
        endcase
    end

    czp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_restart(restart),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .i_cidx   (s_axis_tdata[4:0]),
        .i_cval   (s_axis_tdata[20:5]),
        .i_sample (s_axis_tdata[36:21]),
        .i_free   (free0),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_item   (item)
    );

    czp_linebuf u_linebuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (push && item.is_shift),
        .i_raddr(item.addr),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .o_rdata(lanes)
    );

    czp_window u_window (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg),
        .i_push (push),
        .i_item (item),
        .o_free (free0),
        .i_lanes(lanes),
        .o_we   (we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_v1   (v1),
        .o_prod (prod),
        .o_meta (meta1),
        .i_take (take)
    );

    czp_sum u_sum (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_v    (v1),
        .i_prod (prod),
        .i_meta (meta1),
        .o_take (take),
        .o_valid(sum_valid),
        .o_value(value),
        .o_meta (meta_o),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tvalid = sum_valid;
    assign m_axis_tdata  = {meta_o.col, meta_o.row, value};
    assign m_axis_tlast  = meta_o.last;

endmodule

`default_nettype wire
